// ----- src/i8vq_pkg.sv -----
// Package with payload types, register indexes and widths of the int8 vector quantizer.
package i8vq_pkg;

  localparam int SampleWidth = 20;
  localparam int CodeWidth   = 8;
  localparam int SqWidth     = 2 * SampleWidth;
  localparam int AccWidth    = 51;
  localparam int CfgIdxWidth = 8;

  localparam logic [CfgIdxWidth-1:0] CfgBias      = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgQueryMode = 8'd1;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          in_last;
  } item_t;

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic                 end_of_vector;
    logic [AccWidth-1:0]  half_sq_sum;
  } result_t;

endpackage

// ----- src/int8_vector_quantizer_sq_sum.sv -----
// Top level of the int8 vector quantizer with half sum of squares.
// An accepted item passes through the input stage and then the result stage.
// Throughput: one item per cycle while the result is not stalled; the stage-two accumulate loop sets that figure.
// A stalled result holds; the input stage keeps accepting until it too is full.
// Reset (rst, synchronous): clears bias, query_mode, the accumulator and both valids.
module int8_vector_quantizer_sq_sum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  i8vq_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output i8vq_pkg::result_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i8vq_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [i8vq_pkg::SampleWidth-1:0]   cfg_data
);

  localparam int SW = i8vq_pkg::SampleWidth;
  localparam int AW = i8vq_pkg::AccWidth;
  localparam int QW = i8vq_pkg::SqWidth;

  // configuration registers
  logic signed [SW-1:0] bias;
  logic                 query_mode;

  // stage one: rounded code and square of the element (zero in query mode)
  logic                 s1_valid;
  logic [7:0]           s1_code;
  logic [QW-1:0]        s1_sq;
  logic                 s1_last;

  // running sum of squares
  logic [AW-1:0]        acc;
  logic [AW-1:0]        acc_next;
  logic [AW-1:0]        half_next;
  logic [AW:0]          acc_sum;
  logic [AW-1:0]        acc_sat;

  logic                 item_accept;
  logic                 s2_load;

  logic signed [SW:0]   biased;
  logic signed [SW+1:0] rounded_sum;
  logic signed [SW-7:0] rounded;
  logic [7:0]           code_next;
  logic signed [QW-1:0] sq_next;

  assign cfg_ready = 1'b1;

  // write configuration transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      bias       <= '0;
      query_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i8vq_pkg::CfgBias:      bias       <= cfg_data;
        i8vq_pkg::CfgQueryMode: query_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: advance stage one when the result register is free
  assign s2_load     = s1_valid && (!result_valid || !result_stall);
  assign item_stall  = s1_valid && !s2_load;
  assign item_accept = item_valid && !item_stall;

  // add bias (outside query mode), round half away from zero, clamp to the mode's range
  always_comb begin
    if (query_mode) begin
      biased = {item.sample[SW-1], item.sample};
    end else begin
      biased = {item.sample[SW-1], item.sample} + {bias[SW-1], bias};
    end
    rounded_sum = {biased[SW], biased}
                + (biased[SW] ? (SW+2)'(signed'(127)) : (SW+2)'(signed'(128)));
    rounded = rounded_sum[SW+1:8];
    if (query_mode) begin
      if (rounded < 0)                        code_next = 8'd0;
      else if (rounded > (SW-6)'(signed'(255))) code_next = 8'd255;
      else                                    code_next = rounded[7:0];
    end else begin
      if (rounded < (SW-6)'(signed'(-128)))   code_next = 8'h80;
      else if (rounded > (SW-6)'(signed'(127))) code_next = 8'h7F;
      else                                    code_next = rounded[7:0];
    end
    sq_next = item.sample * item.sample;
  end

  // capture the accepted item into stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_code <= code_next;
      s1_sq   <= (query_mode) ? '0 : QW'(sq_next);
      s1_last <= item.in_last;
    end
  end

  // accumulate with saturation, report and clear on the last element
  always_comb begin
    acc_sum = {1'b0, acc} + (AW+1)'(s1_sq);
    acc_sat = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
    if (s1_last) begin
      acc_next  = '0;
      half_next = query_mode ? '0 : acc_sat;
    end else begin
      acc_next  = acc_sat;
      half_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_load) begin
      acc <= acc_next;
    end
  end

  // result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      result.code          <= s1_code;
      result.end_of_vector <= s1_last;
      result.half_sq_sum   <= half_next;
    end
  end

endmodule

// ----- src/i8vq_checker.sv -----
// Port checker for the int8 vector quantizer and its bind to the top level.
module i8vq_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input i8vq_pkg::result_t result
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // half sum shows only on the last element
  a_half_tail: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.end_of_vector |-> result.half_sq_sum == '0)
    else $error("half sum on a non-final element");

  // an accepted transaction reaches the result register by way of stage one
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |-> ##2 result_valid)
    else $error("result missing two cycles after accept");

endmodule

bind int8_vector_quantizer_sq_sum i8vq_checker u_i8vq_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- tb/tb_int8_vector_quantizer_sq_sum.sv -----
// Self-checking testbench for the int8 vector quantizer with half sum of squares.
`timescale 1ns / 100ps

module tb_int8_vector_quantizer_sq_sum;

  localparam int DrainCycles   = 6;
  localparam int LongHold      = 200;
  localparam int ItemsPerPhase = 112;
  localparam int NumPhases     = 8;
  localparam int NumSteps      = 30;
  localparam longint unsigned AccMax = (64'd1 << i8vq_pkg::AccWidth) - 64'd1;

  typedef enum logic [1:0] {StepItem, StepBias, StepMode} step_kind_t;

  typedef struct packed {
    step_kind_t                       kind;
    logic [i8vq_pkg::SampleWidth-1:0] value;
    logic                             last;
    logic                             typed;
    i8vq_pkg::result_t                want;
  } step_t;

  localparam i8vq_pkg::result_t Predicted = '0;

  // Directed steps: extremes, rounding ties, clamps, bias extremes, mode switches
  localparam step_t DirectedSteps [NumSteps] = '{
    '{StepItem, 20'sd0,       1'b1, 1'b1, {8'h00, 1'b1, 51'd0}},
    '{StepItem, 20'h7FFFF,    1'b0, 1'b1, {8'h7F, 1'b0, 51'd0}},
    '{StepItem, 20'h80000,    1'b0, 1'b1, {8'h80, 1'b0, 51'd0}},
    '{StepItem, 20'sd0,       1'b1, 1'b0, Predicted},
    '{StepItem, 20'sd128,     1'b0, 1'b0, Predicted},
    '{StepItem, -20'sd128,    1'b0, 1'b0, Predicted},
    '{StepItem, 20'sd384,     1'b0, 1'b0, Predicted},
    '{StepItem, -20'sd384,    1'b0, 1'b0, Predicted},
    '{StepItem, 20'sd32640,   1'b0, 1'b0, Predicted},
    '{StepItem, -20'sd32896,  1'b1, 1'b0, Predicted},
    '{StepBias, 20'h7FFFF,    1'b0, 1'b0, Predicted},
    '{StepItem, 20'sd0,       1'b0, 1'b1, {8'h7F, 1'b0, 51'd0}},
    '{StepItem, 20'h80000,    1'b1, 1'b0, Predicted},
    '{StepBias, 20'h80000,    1'b0, 1'b0, Predicted},
    '{StepItem, 20'h80000,    1'b0, 1'b1, {8'h80, 1'b0, 51'd0}},
    '{StepItem, 20'h7FFFF,    1'b1, 1'b0, Predicted},
    '{StepBias, 20'sd0,       1'b0, 1'b0, Predicted},
    '{StepItem, 20'sd1000,    1'b0, 1'b0, Predicted},
    '{StepMode, 20'sd1,       1'b0, 1'b0, Predicted},
    '{StepItem, 20'h80000,    1'b0, 1'b1, {8'h00, 1'b0, 51'd0}},
    '{StepItem, 20'h7FFFF,    1'b0, 1'b1, {8'hFF, 1'b0, 51'd0}},
    '{StepItem, 20'sd65408,   1'b0, 1'b0, Predicted},
    '{StepItem, -20'sd128,    1'b0, 1'b0, Predicted},
    '{StepMode, 20'sd0,       1'b0, 1'b0, Predicted},
    '{StepItem, 20'sd2000,    1'b1, 1'b0, Predicted},
    '{StepItem, 20'sd5000,    1'b0, 1'b0, Predicted},
    '{StepMode, 20'sd1,       1'b0, 1'b0, Predicted},
    '{StepItem, 20'sd384,     1'b1, 1'b1, {8'h02, 1'b1, 51'd0}},
    '{StepMode, 20'sd0,       1'b0, 1'b0, Predicted},
    '{StepItem, 20'sd0,       1'b1, 1'b1, {8'h00, 1'b1, 51'd0}}
  };

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             item_valid   = 1'b0;
  logic                             item_stall;
  i8vq_pkg::item_t                  item         = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  i8vq_pkg::result_t                result;
  logic                             cfg_valid    = 1'b0;
  logic                             cfg_ready;
  logic [i8vq_pkg::CfgIdxWidth-1:0] cfg_index    = '0;
  logic [i8vq_pkg::SampleWidth-1:0] cfg_data     = '0;

  // Predictor state and the codes still owed by the block
  int                            bias_q8;
  bit                            query_on;
  logic [i8vq_pkg::AccWidth-1:0] sq_total;
  i8vq_pkg::result_t             awaited_codes[$];
  int                            errors = 0;

  // Idling controls; the long hold is requested by count, served by the receiver
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;

  int8_vector_quantizer_sq_sum dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round a Q8 value half away from zero
  function automatic int round_half_away(int x);
    if (x < 0) begin
      return -((-x + 128) >>> 8);
    end
    return (x + 128) >>> 8;
  endfunction

  // Quantize one element and advance the square accumulator
  function automatic i8vq_pkg::result_t quantize_element(i8vq_pkg::item_t it);
    int                s;
    int                q;
    longint            sx;
    longint unsigned   total;
    i8vq_pkg::result_t r;
    s = {{(32 - i8vq_pkg::SampleWidth){it.sample[i8vq_pkg::SampleWidth-1]}}, it.sample};
    r = '0;
    r.end_of_vector = it.in_last;
    if (query_on) begin
      q = round_half_away(s);
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      if (it.in_last) sq_total = '0;
    end else begin
      sx = s;
      total = sq_total + longint'(sx * sx);
      if (total > AccMax) total = AccMax;
      q = round_half_away(s + bias_q8);
      if (q < -128) q = -128;
      if (q > 127) q = 127;
      if (it.in_last) begin
        r.half_sq_sum = total[i8vq_pkg::AccWidth-1:0];
        total = 0;
      end
      sq_total = total[i8vq_pkg::AccWidth-1:0];
    end
    r.code = q[i8vq_pkg::CodeWidth-1:0];
    return r;
  endfunction

  function automatic logic [i8vq_pkg::SampleWidth-1:0] random_sample();
    int v;
    case ($urandom_range(9)) inside
      0: v = 32'h7FFFF;
      1: v = -32'sd524288;
      [2:4]: v = $urandom;
      [5:7]: v = $urandom_range(40000);
      default: v = ($urandom_range(300) << 8) + 128;
    endcase
    if ($urandom_range(1) == 1 && $urandom_range(9) > 4) v = -v;
    return v[i8vq_pkg::SampleWidth-1:0];
  endfunction

  // Offer one element with random gaps; record its expected code on acceptance
  task automatic send_item(input i8vq_pkg::item_t it, input bit typed,
                           input i8vq_pkg::result_t want);
    i8vq_pkg::result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = quantize_element(it);
    awaited_codes.push_back(typed ? want : pred);
  endtask

  // Write one register once the block has drained
  task automatic write_reg(input logic [i8vq_pkg::CfgIdxWidth-1:0] idx,
                           input logic [i8vq_pkg::SampleWidth-1:0] data);
    item_valid <= 1'b0;
    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == i8vq_pkg::CfgBias) begin
      bias_q8 = {{(32 - i8vq_pkg::SampleWidth){data[i8vq_pkg::SampleWidth-1]}}, data};
    end else if (idx == i8vq_pkg::CfgQueryMode) begin
      query_on = data[0];
    end
  endtask

  task automatic pick_config(input int phase);
    logic [i8vq_pkg::SampleWidth-1:0] b;
    int                               mag;
    int                               bv;
    case ($urandom_range(4))
      0: b = 20'h7FFFF;
      1: b = 20'h80000;
      2: b = '0;
      default: begin
        mag = $urandom_range(3000);
        bv  = ($urandom_range(1) == 1) ? -mag : mag;
        b   = bv[i8vq_pkg::SampleWidth-1:0];
      end
    endcase
    if (phase == 1) b = 20'h7FFFF;
    if (phase == 4) b = 20'h80000;
    write_reg(i8vq_pkg::CfgBias, b);
    write_reg(i8vq_pkg::CfgQueryMode,
              (phase == 2 || $urandom_range(3) == 0) ? 20'd1 : 20'd0);
  endtask

  // Stream vectors of random length; the phase may cut the last one short
  task automatic stream_vectors(input int n_items);
    int              sent;
    int              len;
    i8vq_pkg::item_t it;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      for (int k = 0; k < len && sent < n_items; k++) begin
        it.sample  = random_sample();
        it.in_last = (k == len - 1);
        send_item(it, 1'b0, Predicted);
        sent++;
      end
    end
  endtask

  // Drive the receiver stall: long hold on request, else random
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= LongHold;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result transaction with the oldest expected code
  always @(posedge clk) begin : check_results
    i8vq_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_codes.size() == 0) begin
        $display("%0t: result with none expected, code %h eov %b half %h",
                 $time, result.code, result.end_of_vector, result.half_sq_sum);
        errors++;
      end else begin
        want = awaited_codes.pop_front();
        if (result.code !== want.code) begin
          $display("%0t: code expected %h got %h", $time, want.code, result.code);
          errors++;
        end
        if (result.end_of_vector !== want.end_of_vector) begin
          $display("%0t: end_of_vector expected %b got %b",
                   $time, want.end_of_vector, result.end_of_vector);
          errors++;
        end
        if (result.half_sq_sum !== want.half_sq_sum) begin
          $display("%0t: half_sq_sum expected %h got %h",
                   $time, want.half_sq_sum, result.half_sq_sum);
          errors++;
        end
      end
    end
  end

  initial begin
    i8vq_pkg::item_t it;
    bias_q8  = 0;
    query_on = 1'b0;
    sq_total = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < NumSteps; i++) begin
      case (DirectedSteps[i].kind)
        StepBias: write_reg(i8vq_pkg::CfgBias, DirectedSteps[i].value);
        StepMode: write_reg(i8vq_pkg::CfgQueryMode, DirectedSteps[i].value);
        default: begin
          it.sample  = DirectedSteps[i].value;
          it.in_last = DirectedSteps[i].last;
          send_item(it, DirectedSteps[i].typed, DirectedSteps[i].want);
        end
      endcase
    end

    // Random phases under different idling
    for (int p = 0; p < NumPhases; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      pick_config(p);
      if (p == 0) hold_req++;
      stream_vectors(ItemsPerPhase);
    end

    // Drain and report
    item_valid <= 1'b0;
    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
src/i8vq_pkg.sv
src/int8_vector_quantizer_sq_sum.sv
src/i8vq_checker.sv
tb/tb_int8_vector_quantizer_sq_sum.sv
